[hw/rtl/lc3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LC-3 executor package
// Shared types, constants and opcode names for the LC-3 instruction executor.
// ----------------------------------------------------------------------------
package lc3_pkg;

   localparam int ADDR_BITS = 16;
   localparam int MEM_DEPTH = 1 << ADDR_BITS;

   localparam logic [15:0] START_PC_RESET = 16'h3000;
   localparam logic [7:0]  HALT_VECTOR    = 8'h25;

   localparam logic [1:0] REQ_MEM_WRITE = 2'd0;
   localparam logic [1:0] REQ_EXECUTE   = 2'd1;
   localparam logic [1:0] REQ_MEM_READ  = 2'd2;
   localparam logic [1:0] REQ_REG_READ  = 2'd3;

   localparam logic [3:0] OP_BR   = 4'd0;
   localparam logic [3:0] OP_ADD  = 4'd1;
   localparam logic [3:0] OP_LD   = 4'd2;
   localparam logic [3:0] OP_ST   = 4'd3;
   localparam logic [3:0] OP_JSR  = 4'd4;
   localparam logic [3:0] OP_AND  = 4'd5;
   localparam logic [3:0] OP_LDR  = 4'd6;
   localparam logic [3:0] OP_STR  = 4'd7;
   localparam logic [3:0] OP_NOT  = 4'd9;
   localparam logic [3:0] OP_LDI  = 4'd10;
   localparam logic [3:0] OP_STI  = 4'd11;
   localparam logic [3:0] OP_JMP  = 4'd12;
   localparam logic [3:0] OP_LEA  = 4'd14;
   localparam logic [3:0] OP_TRAP = 4'd15;

   localparam logic [2:0] CC_N = 3'd4;
   localparam logic [2:0] CC_Z = 3'd2;
   localparam logic [2:0] CC_P = 3'd1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] address;
      logic [15:0] write_data;
      logic [2:0]  reg_index;
   } req_type_type;

   typedef struct packed {
      logic [15:0] read_value;
      logic [15:0] pc_now;
      logic [2:0]  cond_flags;
      logic        trap_taken;
      logic [7:0]  trap_vector;
      logic        halted;
      logic        fault;
   } rsp_type;

   // memory address select for the datapath
   typedef enum logic [1:0] {
      MA_REQ, MA_PC, MA_EA, MA_MDR
   } maddr_sel_type;

   // controller -> datapath
   typedef struct packed {
      logic          load_req;
      maddr_sel_type maddr_sel;
      logic          mem_en;
      logic          mem_we;
      logic          wdata_reg;   // store data from register file
      logic          latch_ir;
      logic          latch_mdr;
      logic          exec;        // perform register/PC/flag update
      logic          load_result; // latch the response fields
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] opcode;
      logic       stopped;
   } sts_type;

   function automatic logic [2:0] cc_of(input logic [15:0] v);
      if (v == 16'd0)  return CC_Z;
      else if (v[15])  return CC_N;
      else             return CC_P;
   endfunction

endpackage

[hw/rtl/lc3_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LC-3 generic RAM
// Single-port word memory with registered read data.
// ----------------------------------------------------------------------------
module lc3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end
         rdata <= mem_ff[addr];
      end
   end

endmodule

[hw/rtl/lc3_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LC-3 datapath
// Register file, PC, flags, instruction and data registers, and word memory.
// ----------------------------------------------------------------------------
module lc3_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  lc3_pkg::req_type_type req,
   input  logic                  csr_we,
   input  logic [15:0]           csr_data,
   input  lc3_pkg::ctl_type      ctl,
   output lc3_pkg::sts_type      sts,
   output lc3_pkg::rsp_type      rsp
);
   import lc3_pkg::*;

   req_type_type req_ff;
   logic [15:0] regs_ff [8];
   logic [15:0] regs_in [8];
   logic [15:0] pc_ff, pc_in, ir_ff, mdr_ff;
   logic [2:0]  cc_ff, cc_in;
   logic        halt_ff, halt_in, fault_ff, fault_in;
   logic        tt_in;
   logic [7:0]  tv_in;
   logic [15:0] rdata, maddr, wdata, pc1, off9, off6, ea, rv_in, srv, b, val;
   logic [ADDR_BITS-1:0] ram_addr;
   logic [3:0]  op;
   logic [2:0]  dr, sr;
   logic        wr_dr;
   rsp_type     rsp_ff;

   assign op   = ir_ff[15:12];
   assign dr   = ir_ff[11:9];
   assign sr   = ir_ff[8:6];
   assign pc1  = pc_ff + 16'd1;
   assign off9 = {{7{ir_ff[8]}}, ir_ff[8:0]};
   assign off6 = {{10{ir_ff[5]}}, ir_ff[5:0]};
   assign srv  = regs_ff[sr];
   assign ea   = (op == OP_LDR || op == OP_STR) ? srv + off6 : pc1 + off9;

   always_comb begin
      case (ctl.maddr_sel)
         MA_REQ:  maddr = req_ff.address;
         MA_PC:   maddr = pc_ff;
         MA_EA:   maddr = ea;
         MA_MDR:  maddr = mdr_ff;
         default: maddr = pc_ff;
      endcase
   end
   assign ram_addr = maddr[ADDR_BITS-1:0];
   assign wdata    = ctl.wdata_reg ? regs_ff[dr] : req_ff.write_data;

   lc3_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_ram (
      .clock (clock),
      .en    (ctl.mem_en),
      .we    (ctl.mem_we),
      .addr  (ram_addr),
      .wdata (wdata),
      .rdata (rdata)
   );

   // execute stage
   always_comb begin
      regs_in  = regs_ff;
      pc_in    = pc_ff;
      cc_in    = cc_ff;
      halt_in  = halt_ff;
      fault_in = fault_ff;
      tt_in    = 1'b0;
      tv_in    = 8'd0;
      wr_dr    = 1'b0;
      val      = 16'd0;
      b        = ir_ff[5] ? {{11{ir_ff[4]}}, ir_ff[4:0]} : regs_ff[ir_ff[2:0]];
      if (ctl.exec) begin
         pc_in = pc1;
         case (op)
            OP_BR:  if ((dr & cc_ff) != 3'd0) pc_in = pc1 + off9;
            OP_ADD: begin wr_dr = 1'b1; val = srv + b; end
            OP_AND: begin wr_dr = 1'b1; val = srv & b; end
            OP_NOT: begin wr_dr = 1'b1; val = ~srv; end
            OP_LD, OP_LDR, OP_LDI: begin wr_dr = 1'b1; val = rdata; end
            OP_LEA: begin wr_dr = 1'b1; val = pc1 + off9; end
            OP_ST, OP_STR, OP_STI: ;
            OP_JSR: begin
               regs_in[7] = pc1;
               pc_in = ir_ff[11] ? pc1 + {{5{ir_ff[10]}}, ir_ff[10:0]} : srv;
            end
            OP_JMP: pc_in = srv;
            OP_TRAP: begin
               tt_in = 1'b1;
               tv_in = ir_ff[7:0];
               if (ir_ff[7:0] == HALT_VECTOR) halt_in = 1'b1;
            end
            default: fault_in = 1'b1;
         endcase
         if (wr_dr) begin
            regs_in[dr] = val;
            cc_in = cc_of(val);
         end
      end
      case (req_ff.req_type)
         REQ_MEM_READ: rv_in = rdata;
         REQ_REG_READ: rv_in = regs_ff[req_ff.reg_index];
         default:      rv_in = 16'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) regs_ff[i] <= 16'd0;
         pc_ff       <= START_PC_RESET;
         cc_ff       <= 3'd0;
         halt_ff     <= 1'b0;
         fault_ff    <= 1'b0;
      end else begin
         regs_ff  <= regs_in;
         cc_ff    <= cc_in;
         halt_ff  <= halt_in;
         fault_ff <= fault_in;
         if (csr_we) begin
            pc_ff       <= csr_data;
         end else begin
            pc_ff <= pc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req)  req_ff <= req;
      if (ctl.latch_ir)  ir_ff  <= rdata;
      if (ctl.latch_mdr) mdr_ff <= rdata;
      if (ctl.load_result) begin
         rsp_ff.read_value  <= rv_in;
         rsp_ff.pc_now      <= csr_we ? csr_data : pc_in;
         rsp_ff.cond_flags  <= cc_in;
         rsp_ff.trap_taken  <= tt_in;
         rsp_ff.trap_vector <= tv_in;
         rsp_ff.halted      <= halt_in;
         rsp_ff.fault       <= fault_in;
      end
   end

   assign rsp = rsp_ff;
   assign sts.req_type = req_ff.req_type;
   assign sts.opcode   = op;
   assign sts.stopped  = halt_ff | fault_ff;

endmodule

[hw/rtl/lc3_control.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LC-3 controller
// Sequences request decode, fetch, memory accesses, execute and result.
// ----------------------------------------------------------------------------
module lc3_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   input  lc3_pkg::sts_type sts,
   output lc3_pkg::ctl_type ctl
);
   import lc3_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_FETCH, ST_ACCESS, ST_INDIRECT, ST_EXEC, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in, valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      valid_in = 1'b0;
      ctl      = '0;
      ctl.maddr_sel = MA_PC;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.load_req = 1'b1;
               busy_in  = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.req_type)
               REQ_MEM_WRITE: begin
                  ctl.maddr_sel = MA_REQ;
                  ctl.mem_en = 1'b1;
                  ctl.mem_we = 1'b1;
                  state_in = ST_DONE;
               end
               REQ_MEM_READ: begin
                  ctl.maddr_sel = MA_REQ;
                  ctl.mem_en = 1'b1;
                  state_in = ST_DONE;
               end
               REQ_EXECUTE: begin
                  if (sts.stopped) begin
                     state_in = ST_DONE;
                  end else begin
                     ctl.mem_en = 1'b1;
                     state_in = ST_FETCH;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_FETCH: begin
            ctl.latch_ir = 1'b1;
            state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            ctl.maddr_sel = MA_EA;
            case (sts.opcode)
               OP_LD, OP_LDR, OP_LDI, OP_STI: begin
                  ctl.mem_en = 1'b1;
                  state_in = (sts.opcode == OP_LDI || sts.opcode == OP_STI)
                             ? ST_INDIRECT : ST_EXEC;
               end
               OP_ST, OP_STR: begin
                  ctl.mem_en = 1'b1;
                  ctl.mem_we = 1'b1;
                  ctl.wdata_reg = 1'b1;
                  state_in = ST_EXEC;
               end
               default: state_in = ST_EXEC;
            endcase
         end
         ST_INDIRECT: begin
            ctl.latch_mdr = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            ctl.maddr_sel = MA_MDR;
            // second indirect access uses the latched pointer
            if (sts.opcode == OP_LDI) begin
               ctl.mem_en = 1'b1;
               state_in = ST_DONE;
            end else if (sts.opcode == OP_STI) begin
               ctl.mem_en = 1'b1;
               ctl.mem_we = 1'b1;
               ctl.wdata_reg = 1'b1;
               ctl.exec = 1'b1;
               ctl.load_result = 1'b1;
               valid_in = 1'b1;
               busy_in  = 1'b0;
               state_in = ST_IDLE;
            end else begin
               ctl.exec = 1'b1;
               ctl.load_result = 1'b1;
               valid_in = 1'b1;
               busy_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            ctl.exec = (sts.req_type == REQ_EXECUTE) && !sts.stopped;
            ctl.load_result = 1'b1;
            valid_in = 1'b1;
            busy_in  = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

endmodule

[hw/rtl/lc3_instruction_executor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LC-3 instruction executor
// Memory/register requests pass through the decode and done states; an
// instruction through decode, fetch, access and execute, with an indirect state
// for LDI/STI and a done state for LDI, as the memory port is single. busy
// drops as the strobe rises; no request is taken while busy. Receiver cannot
// stall. Reset clears registers, flags and PC (to 0x3000); memory is not cleared.
// ----------------------------------------------------------------------------
module lc3_instruction_executor (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lc3_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   output lc3_pkg::rsp_type      rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_data
);
   import lc3_pkg::*;

   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;

   lc3_control u_control (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .ctl       (ctl)
   );

   lc3_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req      (req_data),
      .csr_we   (csr_valid),
      .csr_data (csr_data),
      .ctl      (ctl),
      .sts      (sts),
      .rsp      (rsp_data)
   );

endmodule

[tb/lc3_instruction_executor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LC-3 instruction executor testbench
// Drives memory, register and execute requests through the start/busy port,
// predicts every response with a cycle-free model of the core and compares
// each strobed response field by field. The start PC register is rewritten
// between phases, including its extremes.
// ----------------------------------------------------------------------------
module lc3_instruction_executor_tb;
   import lc3_pkg::*;

   localparam logic [3:0] OP_RTI = 4'd8;
   localparam logic [3:0] OP_RES = 4'd13;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_data = '0;

   lc3_instruction_executor uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // core image kept by the predictor
   logic [15:0] mem_img [0:MEM_DEPTH-1];
   bit          mem_known [0:MEM_DEPTH-1];
   logic [15:0] known_addrs [$];
   logic [15:0] gpr [0:7];
   logic [15:0] pc_reg;
   logic [2:0]  cc_reg;
   logic        halt_reg;
   logic        fault_reg;

   req_type_type pending_reqs [$];
   rsp_type      expected_rsps [$];
   int  errors = 0;
   int  idle_left = 0;
   bit  quiet = 0;

   function automatic logic [2:0] flags_of(input logic [15:0] v);
      if (v == 16'd0) return CC_Z;
      if (v[15]) return CC_N;
      return CC_P;
   endfunction

   task automatic store_word(input logic [15:0] a, input logic [15:0] v);
      mem_img[a] = v;
      if (!mem_known[a]) begin
         mem_known[a] = 1;
         known_addrs.push_back(a);
      end
   endtask

   task automatic load_gpr(input logic [2:0] r, input logic [15:0] v);
      gpr[r] = v;
      cc_reg = flags_of(v);
   endtask

   task automatic run_instruction(output logic tt, output logic [7:0] tv);
      logic [15:0] ins, off9, off6, base;
      logic [3:0]  op;
      ins = mem_img[pc_reg];
      op = ins[15:12];
      off9 = {{7{ins[8]}}, ins[8:0]};
      off6 = {{10{ins[5]}}, ins[5:0]};
      tt = 0;
      tv = '0;
      pc_reg = pc_reg + 16'd1;
      case (op)
         OP_BR: if ((ins[11:9] & cc_reg) != 3'd0) pc_reg = pc_reg + off9;
         OP_ADD, OP_AND: begin
            base = ins[5] ? {{11{ins[4]}}, ins[4:0]} : gpr[ins[2:0]];
            if (op == OP_ADD) load_gpr(ins[11:9], gpr[ins[8:6]] + base);
            else load_gpr(ins[11:9], gpr[ins[8:6]] & base);
         end
         OP_LD:  load_gpr(ins[11:9], mem_img[pc_reg + off9]);
         OP_ST:  store_word(pc_reg + off9, gpr[ins[11:9]]);
         OP_JSR: begin
            base = gpr[ins[8:6]];
            gpr[7] = pc_reg;
            if (ins[11]) pc_reg = pc_reg + {{5{ins[10]}}, ins[10:0]};
            else pc_reg = base;
         end
         OP_LDR: load_gpr(ins[11:9], mem_img[gpr[ins[8:6]] + off6]);
         OP_STR: store_word(gpr[ins[8:6]] + off6, gpr[ins[11:9]]);
         OP_NOT: load_gpr(ins[11:9], ~gpr[ins[8:6]]);
         OP_LDI: load_gpr(ins[11:9], mem_img[mem_img[pc_reg + off9]]);
         OP_STI: store_word(mem_img[pc_reg + off9], gpr[ins[11:9]]);
         OP_JMP: pc_reg = gpr[ins[8:6]];
         OP_LEA: load_gpr(ins[11:9], pc_reg + off9);
         OP_TRAP: begin
            tt = 1;
            tv = ins[7:0];
            if (ins[7:0] == HALT_VECTOR) halt_reg = 1;
         end
         default: fault_reg = 1;
      endcase
   endtask

   task automatic apply_request(input req_type_type r, output rsp_type e);
      logic       tt;
      logic [7:0] tv;
      e = '0;
      case (r.req_type)
         REQ_MEM_WRITE: store_word(r.address, r.write_data);
         REQ_EXECUTE: if (!halt_reg && !fault_reg) begin
            run_instruction(tt, tv);
            e.trap_taken = tt;
            e.trap_vector = tv;
         end
         REQ_MEM_READ: e.read_value = mem_img[r.address];
         default: e.read_value = gpr[r.reg_index];
      endcase
      e.pc_now = pc_reg;
      e.cond_flags = cc_reg;
      e.halted = halt_reg;
      e.fault = fault_reg;
   endtask

   // driver: transfer at start && !busy, hold otherwise
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (start && !busy) begin
            apply_request(req_data, e);
            expected_rsps.push_back(e);
            void'(pending_reqs.pop_front());
         end
         if (!(start && busy)) begin
            if (idle_left > 0) begin
               idle_left = idle_left - 1;
               start <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
               idle_left = $urandom_range(1, 14);
               start <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               start <= 1'b1;
               req_data <= pending_reqs[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      end
   endtask

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: expected none, actual %h", $time, rsp_data);
         end else begin
            e = expected_rsps.pop_front();
            check_field("read_value", e.read_value, rsp_data.read_value);
            check_field("pc_now", e.pc_now, rsp_data.pc_now);
            check_field("cond_flags", 16'(e.cond_flags), 16'(rsp_data.cond_flags));
            check_field("trap_taken", 16'(e.trap_taken), 16'(rsp_data.trap_taken));
            check_field("trap_vector", 16'(e.trap_vector), 16'(rsp_data.trap_vector));
            check_field("halted", 16'(e.halted), 16'(rsp_data.halted));
            check_field("fault", 16'(e.fault), 16'(rsp_data.fault));
         end
      end
   end

   task automatic send(input logic [1:0] kind, input logic [15:0] a,
                       input logic [15:0] d, input logic [2:0] ri);
      req_type_type r;
      r.req_type = kind;
      r.address = a;
      r.write_data = d;
      r.reg_index = ri;
      pending_reqs.push_back(r);
      while (pending_reqs.size() != 0) @(negedge clock);
   endtask

   task automatic ensure_word(input logic [15:0] a);
      if (!mem_known[a]) send(REQ_MEM_WRITE, a, 16'($urandom), 3'($urandom));
   endtask

   // place the instruction at the PC, back its operands, then step
   task automatic exec_word(input logic [15:0] w);
      logic [15:0] ea;
      logic [3:0]  op;
      op = w[15:12];
      send(REQ_MEM_WRITE, pc_reg, w, 3'($urandom));
      if (op == OP_LDR) ea = gpr[w[8:6]] + {{10{w[5]}}, w[5:0]};
      else ea = pc_reg + 16'd1 + {{7{w[8]}}, w[8:0]};
      if (op == OP_LD || op == OP_LDI || op == OP_LDR || op == OP_STI) ensure_word(ea);
      if (op == OP_LDI) ensure_word(mem_img[ea]);
      send(REQ_EXECUTE, 16'($urandom), 16'($urandom), 3'($urandom));
   endtask

   task automatic random_item();
      logic [3:0]  op;
      logic [15:0] w, a;
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) begin
         do op = 4'($urandom); while (op == OP_RTI || op == OP_RES);
         w = {op, 12'($urandom)};
         if (op == OP_TRAP && w[7:0] == HALT_VECTOR) w[1] = ~w[1];
         exec_word(w);
      end else if (k < 70) begin
         a = ($urandom_range(0, 1) == 0) ? pc_reg + 16'($urandom_range(0, 300))
                                         : 16'($urandom);
         send(REQ_MEM_WRITE, a, 16'($urandom), 3'($urandom));
      end else if (k < 85) begin
         a = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
         send(REQ_MEM_READ, a, 16'($urandom), 3'($urandom));
      end else begin
         send(REQ_REG_READ, 16'($urandom), 16'($urandom), 3'($urandom));
      end
   endtask

   task automatic write_start_pc(input logic [15:0] v);
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      pc_reg = v;
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [15:0] phase_pc [0:3];
      for (int i = 0; i < 8; i++) gpr[i] = '0;
      pc_reg = START_PC_RESET;
      cc_reg = '0;
      halt_reg = 0;
      fault_reg = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      exec_word(16'h0E05);                  // no flags yet: branch not taken
      send(REQ_MEM_WRITE, 16'h0000, 16'hFFFF, 3'd0);
      send(REQ_MEM_WRITE, 16'hFFFF, 16'h0000, 3'd7);
      send(REQ_MEM_READ, 16'h0000, 16'h0000, 3'd0);
      send(REQ_MEM_READ, 16'hFFFF, 16'hFFFF, 3'd7);
      exec_word(16'h5020);
      exec_word(16'h127F);
      exec_word(16'h1441);
      exec_word(16'h967F);
      exec_word(16'h190F);
      exec_word(16'hEB00);
      exec_word(16'hECFF);
      exec_word(16'h0E02);
      exec_word(16'h4BFF);
      exec_word(16'h41C0);                  // JSRR R7 uses the old R7
      exec_word(16'hC1C0);
      exec_word(16'h2000);
      exec_word(16'h6360);
      exec_word(16'hA400);
      exec_word(16'h3201);
      exec_word(16'h7F9F);
      exec_word(16'hB7FF);
      exec_word(16'hF000);
      exec_word(16'hF0FF);
      send(REQ_REG_READ, 16'h0000, 16'h0000, 3'd7);

      phase_pc[0] = 16'h0000;
      phase_pc[1] = 16'hFFFF;
      phase_pc[2] = 16'($urandom);
      phase_pc[3] = START_PC_RESET;
      for (int p = 0; p < 4; p++) begin
         write_start_pc(phase_pc[p]);
         if (p == 3) quiet = 1;
         for (int n = 0; n < 85; n++) random_item();
      end

      // stop the core one way or the other, then check it stays stopped
      if ($urandom_range(0, 1) == 0) exec_word({OP_TRAP, 4'd0, HALT_VECTOR});
      else exec_word({($urandom_range(0, 1) == 0) ? OP_RTI : OP_RES, 12'($urandom)});
      exec_word(16'h1021);
      exec_word(16'hF0FF);
      send(REQ_REG_READ, 16'h0000, 16'h0000, 3'd0);

      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/lc3_pkg.sv
hw/rtl/lc3_ram.sv
hw/rtl/lc3_datapath.sv
hw/rtl/lc3_control.sv
hw/rtl/lc3_instruction_executor.sv
tb/lc3_instruction_executor_tb.sv
